FILE: sv/hbm_pkg.sv
// Shared types and constants of the heartbeat liveness monitor.
`default_nettype none

package hbm_pkg;

    // Datagram layout, byte offsets from the start of the datagram
    localparam int FRAME_BYTES  = 29;
    localparam int OFS_MAGIC    = 0;
    localparam int OFS_VERSION  = 4;
    localparam int OFS_SESSION  = 5;
    localparam int OFS_SEQUENCE = 13;
    localparam int OFS_STAMP    = 21;

    localparam int MAGIC_BYTES   = OFS_VERSION - OFS_MAGIC;
    localparam int SESSION_BYTES = OFS_SEQUENCE - OFS_SESSION;
    localparam int SEQ_BYTES     = OFS_STAMP - OFS_SEQUENCE;

    localparam int POS_BITS = 6;
    localparam logic [POS_BITS-1:0] POS_MAX   = {POS_BITS{1'b1}};
    localparam logic [POS_BITS-1:0] POS_FINAL = POS_BITS'(FRAME_BYTES - 1);

    // Width of the accept and reject totals
    localparam int COUNTER_BITS = 32;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    // Configuration reset values
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [31:0] MAGIC_RESET   = 32'd0;
    localparam logic [7:0]  VERSION_RESET = 8'd1;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_MAGIC   = 2'd1,
        CFG_VERSION = 2'd2
    } t_cfg_idx;

    // One datagram byte handed to the assembler
    typedef struct packed {
        logic       step;
        logic [7:0] data;
        logic       last;
    } t_byte_in;

    // Fields gathered so far for the open datagram
    typedef struct packed {
        logic [POS_BITS-1:0]      pos;
        logic [8*MAGIC_BYTES-1:0] magic;
        logic [7:0]               version;
        logic [8*SESSION_BYTES-1:0] session;
        logic [8*SEQ_BYTES-1:0]   seq_num;
    } t_rx_frame;

endpackage

`default_nettype wire

FILE: sv/hbm_asm.sv
// Byte assembler: gathers magic, version, session and sequence of a datagram.
`default_nettype none

module hbm_asm (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire hbm_pkg::t_byte_in i_byte,
    output hbm_pkg::t_rx_frame   o_frame
);

    hbm_pkg::t_rx_frame r_frame;
    hbm_pkg::t_rx_frame n_frame;

    always_comb begin
        n_frame = r_frame;
        if (i_byte.step) begin
            if (i_byte.last) begin
                // close: start the next datagram from empty
                n_frame = '0;
            end else begin
                for (int k = 0; k < hbm_pkg::MAGIC_BYTES; k++) begin
                    if (r_frame.pos == hbm_pkg::POS_BITS'(hbm_pkg::OFS_MAGIC + k)) begin
                        n_frame.magic[8*k +: 8] = i_byte.data;
                    end
                end
                if (r_frame.pos == hbm_pkg::POS_BITS'(hbm_pkg::OFS_VERSION)) begin
                    n_frame.version = i_byte.data;
                end
                for (int k = 0; k < hbm_pkg::SESSION_BYTES; k++) begin
                    if (r_frame.pos == hbm_pkg::POS_BITS'(hbm_pkg::OFS_SESSION + k)) begin
                        n_frame.session[8*k +: 8] = i_byte.data;
                    end
                end
                for (int k = 0; k < hbm_pkg::SEQ_BYTES; k++) begin
                    if (r_frame.pos == hbm_pkg::POS_BITS'(hbm_pkg::OFS_SEQUENCE + k)) begin
                        n_frame.seq_num[8*k +: 8] = i_byte.data;
                    end
                end
                // hold the position at its top on overlong datagrams
                if (r_frame.pos != hbm_pkg::POS_MAX) begin
                    n_frame.pos = r_frame.pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else begin
            r_frame <= n_frame;
        end
    end

    assign o_frame = r_frame;

endmodule

`default_nettype wire

FILE: sv/heartbeat_liveness_monitor.sv
// Top level of the heartbeat liveness monitor.
// Usage:
//   The s_axis channel carries one item per byte of a heartbeat datagram
//   (tuser = 0, tdata = byte, tlast on the final byte) or one time tick
//   (tuser = 1, tdata and tlast ignored). Every accepted item yields exactly
//   one result item on m_axis: tlast flags that the item closed a datagram,
//   tuser carries the accepted/alive/ever-received flags and tdata the
//   accept count, reject count and ticks since the last accepted datagram.
//   A closed datagram passes when it is 29 bytes long, matches the magic
//   word and version, and is new (no session yet, a different session, or a
//   higher sequence number in the same session).
//   An item taken on s_axis moves into the input register, then into the
//   result register, from which its result is offered on m_axis.
//   Throughput: one item per cycle while m_axis is ready, set by the single
//   pass of byte assembly and 64-bit compares between the two registers.
//   When m_axis stalls, the result register holds and the input register
//   still takes one more item; s_axis_tready drops only when both are full.
//   The cfg channel (always ready) writes timeout, magic word and version;
//   write it only while no item is in flight. Reset (synchronous, active low)
//   clears counters, open datagram and held session; restores the defaults.
`default_nettype none

module heartbeat_liveness_monitor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // byte / tick items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tlast,   // last_byte
    input  wire         s_axis_tuser,   // [0] op
    // result items
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] accepted_count, [63:32] rejected_count,
                                        // [95:64] ticks_since_last
    output logic        m_axis_tlast,   // datagram_done
    output logic [2:0]  m_axis_tuser,   // [0] datagram_accepted, [1] alive, [2] ever_received
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);

    // configuration registers
    logic [31:0] r_timeout;
    logic [31:0] r_magic;
    logic [7:0]  r_version;

    // input register
    logic        r_in_valid;
    logic        r_in_op;
    logic [7:0]  r_in_data;
    logic        r_in_last;

    // monitor state
    logic [63:0] r_held_session;
    logic [63:0] r_held_seq;
    logic        r_seen_any;
    logic [31:0] r_elapsed;
    logic [hbm_pkg::COUNTER_BITS-1:0] r_acc_total;
    logic [hbm_pkg::COUNTER_BITS-1:0] r_rej_total;

    logic [63:0] n_held_session;
    logic [63:0] n_held_seq;
    logic        n_seen_any;
    logic [31:0] n_elapsed;
    logic [hbm_pkg::COUNTER_BITS-1:0] n_acc_total;
    logic [hbm_pkg::COUNTER_BITS-1:0] n_rej_total;

    // result register
    logic        r_out_valid;
    logic        r_out_done;
    logic        r_out_accepted;
    logic        r_out_alive;
    logic        r_out_ever;
    logic [31:0] r_out_acc;
    logic [31:0] r_out_rej;
    logic [31:0] r_out_ticks;

    logic        advance;
    logic        is_tick;
    logic        closing;
    logic        frame_ok;
    logic        fresh;
    logic        accept;
    logic        reject;

    hbm_pkg::t_byte_in  asm_in;
    hbm_pkg::t_rx_frame rx;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= hbm_pkg::TIMEOUT_RESET;
            r_magic   <= hbm_pkg::MAGIC_RESET;
            r_version <= hbm_pkg::VERSION_RESET;
        end else if (i_cfg_valid) begin
            unique case (hbm_pkg::t_cfg_idx'(i_cfg_index))
                hbm_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                hbm_pkg::CFG_MAGIC:   r_magic   <= i_cfg_data;
                hbm_pkg::CFG_VERSION: r_version <= i_cfg_data[7:0];
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    // ---------------- input register ----------------
    // Advance when the result register is free or being drained.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // ---------------- datagram assembly ----------------
    assign is_tick = (hbm_pkg::t_op'(r_in_op) == hbm_pkg::OP_TICK);

    assign asm_in.step = advance && !is_tick;
    assign asm_in.data = r_in_data;
    assign asm_in.last = r_in_last;

    hbm_asm u_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (asm_in),
        .o_frame (rx)
    );

    // ---------------- verdict and state update ----------------
    // The closing byte lands in the timestamp area on a well-sized datagram,
    // so the assembled fields are already complete when it arrives.
    assign closing  = !is_tick && r_in_last;
    assign frame_ok = (rx.pos == hbm_pkg::POS_FINAL) && (rx.magic == r_magic)
                      && (rx.version == r_version);
    assign fresh    = !r_seen_any || (rx.session != r_held_session);
    assign accept   = closing && frame_ok && (fresh || (rx.seq_num > r_held_seq));
    assign reject   = closing && !accept;

    always_comb begin
        n_held_session = r_held_session;
        n_held_seq     = r_held_seq;
        n_seen_any     = r_seen_any;
        n_elapsed      = r_elapsed;
        n_acc_total    = r_acc_total;
        n_rej_total    = r_rej_total;
        if (accept) begin
            n_held_session = rx.session;
            n_held_seq     = rx.seq_num;
            n_seen_any     = 1'b1;
            n_elapsed      = '0;
            if (r_acc_total != hbm_pkg::CNT_MAX) begin
                n_acc_total = r_acc_total + 1'b1;
            end
        end
        if (reject && (r_rej_total != hbm_pkg::CNT_MAX)) begin
            n_rej_total = r_rej_total + 1'b1;
        end
        // saturate the tick count at all ones
        if (is_tick && (r_elapsed != '1)) begin
            n_elapsed = r_elapsed + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_session <= '0;
            r_held_seq     <= '0;
            r_seen_any     <= 1'b0;
            r_elapsed      <= '0;
            r_acc_total    <= '0;
            r_rej_total    <= '0;
        end else if (advance) begin
            r_held_session <= n_held_session;
            r_held_seq     <= n_held_seq;
            r_seen_any     <= n_seen_any;
            r_elapsed      <= n_elapsed;
            r_acc_total    <= n_acc_total;
            r_rej_total    <= n_rej_total;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_done     <= closing;
            r_out_accepted <= accept;
            r_out_alive    <= n_seen_any && (n_elapsed <= r_timeout);
            r_out_ever     <= n_seen_any;
            r_out_acc      <= 32'(n_acc_total);
            r_out_rej      <= 32'(n_rej_total);
            r_out_ticks    <= n_seen_any ? n_elapsed : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_done;
    assign m_axis_tuser  = {r_out_ever, r_out_alive, r_out_accepted};
    assign m_axis_tdata  = {r_out_ticks, r_out_rej, r_out_acc};

    // ---------------- assertions ----------------
    a_advance_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("item advanced but no result held");

    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_accepted |-> r_out_done && (r_out_ticks == '0))
        else $error("accepted result without close or with nonzero ticks");

    a_alive_needs_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_alive |-> r_out_ever)
        else $error("alive without any accepted datagram");

    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_seen_any))
        else $error("seen flag dropped outside reset");

    a_tick_keeps_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && is_tick |=> $stable(rx))
        else $error("tick item disturbed the open datagram");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the heartbeat liveness monitor.
module tb;

    // Sender and receiver pacing
    localparam int LONG_HOLD     = 300;   // receiver hold-off that backs up the input
    localparam int RANDOM_ITEMS  = 1440;
    localparam int RANDOM_PHASES = 4;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;

    // One result item as the block reports it
    typedef struct packed {
        logic        done;
        logic        accepted;
        logic        alive;
        logic        ever;
        logic [31:0] acc_cnt;
        logic [31:0] rej_cnt;
        logic [31:0] ticks;
    } t_hb_report;

    // One row of the directed plan: a tick burst, a datagram or a register write
    typedef enum logic [1:0] {
        ROW_TICKS,
        ROW_FRAME,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        int                count;      // ticks in the burst or bytes in the datagram
        logic [31:0]       magic;
        logic [7:0]        version;
        logic [63:0]       session;
        logic [63:0]       seq_no;
        hbm_pkg::t_cfg_idx reg_idx;
        logic [31:0]       value;
        logic              typed;      // compare the closing item against want
        t_hb_report        want;
    } t_plan_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;

    heartbeat_liveness_monitor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Liveness predictor: own copy of the configuration and of the state
    // ------------------------------------------------------------------
    logic [31:0]             cfg_timeout = hbm_pkg::TIMEOUT_RESET;
    logic [31:0]             cfg_magic   = hbm_pkg::MAGIC_RESET;
    logic [7:0]              cfg_version = hbm_pkg::VERSION_RESET;

    logic [hbm_pkg::POS_BITS-1:0]     rx_pos     = '0;
    logic [31:0]                      rx_magic   = '0;
    logic [7:0]                       rx_version = '0;
    logic [63:0]                      rx_session = '0;
    logic [63:0]                      rx_seq     = '0;
    logic [63:0]                      held_sess  = '0;
    logic [63:0]                      held_seq   = '0;
    logic                             seen_any   = 1'b0;
    logic [31:0]                      idle_ticks = '0;
    logic [hbm_pkg::COUNTER_BITS-1:0] accept_tot = '0;
    logic [hbm_pkg::COUNTER_BITS-1:0] reject_tot = '0;

    t_hb_report pending_reports [$];   // expected result items, oldest first

    int  items_sent    = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;
    int  hold_requests = 0;            // bumped by the stimulus, consumed by the receiver
    int  holds_taken   = 0;
    logic calm         = 1'b0;         // no idling on either side while set

    // Advance the predictor by one accepted item and return what it reports
    function automatic t_hb_report predict_liveness(hbm_pkg::t_op op, logic [7:0] b,
                                                    logic last);
        t_hb_report r;
        logic       ok;
        logic       fresh;
        int         p;
        r = '0;
        if (op == hbm_pkg::OP_TICK) begin
            if (idle_ticks != '1) idle_ticks++;
        end else begin
            p = int'(rx_pos);
            // Gather the header fields; stamp and overflow bytes are dropped
            if (p < hbm_pkg::OFS_VERSION) rx_magic[8*p +: 8] = b;
            else if (p == hbm_pkg::OFS_VERSION) rx_version = b;
            else if (p < hbm_pkg::OFS_SEQUENCE)
                rx_session[8*(p-hbm_pkg::OFS_SESSION) +: 8] = b;
            else if (p < hbm_pkg::OFS_STAMP)
                rx_seq[8*(p-hbm_pkg::OFS_SEQUENCE) +: 8] = b;
            if (last) begin
                ok = (p == hbm_pkg::FRAME_BYTES - 1) && rx_magic == cfg_magic &&
                     rx_version == cfg_version;
                fresh = !seen_any || rx_session != held_sess;
                if (ok && !fresh && rx_seq <= held_seq) ok = 1'b0;
                if (ok) begin
                    held_sess  = rx_session;
                    held_seq   = rx_seq;
                    idle_ticks = '0;
                    seen_any   = 1'b1;
                    if (accept_tot != '1) accept_tot++;
                    r.accepted = 1'b1;
                end else if (reject_tot != '1) begin
                    reject_tot++;
                end
                r.done     = 1'b1;
                rx_pos     = '0;
                rx_magic   = '0;
                rx_version = '0;
                rx_session = '0;
                rx_seq     = '0;
            end else if (rx_pos != hbm_pkg::POS_MAX) begin
                rx_pos++;
            end
        end
        r.alive   = seen_any && idle_ticks <= cfg_timeout;
        r.ever    = seen_any;
        r.acc_cnt = accept_tot[31:0];
        r.rej_cnt = reject_tot[31:0];
        r.ticks   = seen_any ? idle_ticks : '0;
        return r;
    endfunction

    function automatic t_hb_report report(logic d, logic a, logic al, logic ev,
                                          logic [31:0] ac, logic [31:0] rc,
                                          logic [31:0] tk);
        t_hb_report r;
        r = '{d, a, al, ev, ac, rc, tk};
        return r;
    endfunction

    // Byte p of a datagram built from its header fields
    function automatic logic [7:0] frame_byte(int p, logic [31:0] mg, logic [7:0] vr,
                                              logic [63:0] ss, logic [63:0] sq);
        if (p < hbm_pkg::OFS_VERSION) return mg[8*p +: 8];
        if (p == hbm_pkg::OFS_VERSION) return vr;
        if (p < hbm_pkg::OFS_SEQUENCE) return ss[8*(p-hbm_pkg::OFS_SESSION) +: 8];
        if (p < hbm_pkg::OFS_STAMP) return sq[8*(p-hbm_pkg::OFS_SEQUENCE) +: 8];
        return 8'($urandom);
    endfunction

    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Directed plan builders
    // ------------------------------------------------------------------
    function automatic t_plan_row tick_row(int n);
        t_plan_row r;
        r = '{ROW_TICKS, n, '0, '0, '0, '0, hbm_pkg::CFG_TIMEOUT, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_plan_row frame_row(int len, logic [31:0] mg, logic [7:0] vr,
                                            logic [63:0] ss, logic [63:0] sq);
        t_plan_row r;
        r = '{ROW_FRAME, len, mg, vr, ss, sq, hbm_pkg::CFG_TIMEOUT, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_plan_row write_row(hbm_pkg::t_cfg_idx idx, logic [31:0] val);
        t_plan_row r;
        r = '{ROW_WRITE, 0, '0, '0, '0, '0, idx, val, 1'b0, '0};
        return r;
    endfunction

    function automatic t_plan_row checked(t_plan_row r, t_hb_report w);
        r.typed = 1'b1;
        r.want  = w;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one item after a random gap, hold it until taken, then predict it.
    // A typed expectation replaces the predicted one for that item.
    task automatic send_item(hbm_pkg::t_op op, logic [7:0] b, logic last, logic typed,
                             t_hb_report want);
        int         gap;
        t_hb_report r;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_liveness(op, b, last);
        pending_reports.push_back(typed ? want : r);
        items_sent++;
    endtask

    // Send a datagram of len bytes; flip the byte at bad_pos when it is in range
    task automatic send_frame(int len, logic [31:0] mg, logic [7:0] vr, logic [63:0] ss,
                              logic [63:0] sq, int bad_pos, logic typed,
                              t_hb_report want);
        logic [7:0] b;
        for (int p = 0; p < len; p++) begin
            b = frame_byte(p, mg, vr, ss, sq);
            if (p == bad_pos) b ^= 8'($urandom_range(1, 255));
            send_item(hbm_pkg::OP_BYTE, b, p == len - 1, typed && p == len - 1, want);
        end
    endtask

    task automatic send_ticks(int n);
        for (int k = 0; k < n; k++) begin
            send_item(hbm_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
        end
    endtask

    // Write one register with the block idle: drain all results, let the
    // pipeline settle, then complete the handshake and update the predictor
    task automatic write_reg(hbm_pkg::t_cfg_idx idx, logic [31:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            hbm_pkg::CFG_TIMEOUT: cfg_timeout = val;
            hbm_pkg::CFG_MAGIC:   cfg_magic   = val;
            hbm_pkg::CFG_VERSION: cfg_version = val[7:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int roll;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_taken) begin
                // Hold off long enough for the block to fill and stall its input
                holds_taken++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 62) begin
                    m_axis_tready <= 1'b1;
                end else if (roll < 95) begin
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each taken result with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_hb_report got;
        t_hb_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2],
                    m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64]};
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: result %0d arrived with nothing pending", results_seen);
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("tb: result %0d expected done=%0b acc=%0b alive=%0b ever=%0b acc_cnt=%0d rej_cnt=%0d ticks=%0d",
                                 results_seen, want.done, want.accepted, want.alive,
                                 want.ever, want.acc_cnt, want.rej_cnt, want.ticks);
                        $display("tb: result %0d actual   done=%0b acc=%0b alive=%0b ever=%0b acc_cnt=%0d rej_cnt=%0d ticks=%0d",
                                 results_seen, got.done, got.accepted, got.alive,
                                 got.ever, got.acc_cnt, got.rej_cnt, got.ticks);
                    end
                end
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_plan_row   plan [$];
        logic [63:0] sess_pool [4];
        int          roll;
        int          phase_end;
        int          wait_cycles;
        logic [31:0] to_val;
        logic [31:0] mg;
        logic [7:0]  vr;
        logic [63:0] ss;
        logic [63:0] sq;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset configuration first (timeout 1000, magic 0, version 1)
        plan.push_back(checked(tick_row(1),
                               report(1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0)));
        // Lone closing byte: wrong length, rejected before anything was seen
        plan.push_back(checked(frame_row(1, 32'd0, 8'd1, 64'd0, 64'd0),
                               report(1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd1, 32'd0)));
        // First datagram is taken whatever its sequence number
        plan.push_back(checked(frame_row(hbm_pkg::FRAME_BYTES, 32'd0, 8'd1, 64'd0, 64'd0),
                               report(1'b1, 1'b1, 1'b1, 1'b1, 32'd1, 32'd1, 32'd0)));
        // Same session, same sequence: stale, rejected
        plan.push_back(checked(frame_row(hbm_pkg::FRAME_BYTES, 32'd0, 8'd1, 64'd0, 64'd0),
                               report(1'b1, 1'b0, 1'b1, 1'b1, 32'd1, 32'd2, 32'd0)));
        plan.push_back(tick_row(3));
        plan.push_back(frame_row(hbm_pkg::FRAME_BYTES, 32'd0, 8'd1, 64'd0, 64'd1));
        plan.push_back(frame_row(hbm_pkg::FRAME_BYTES, 32'd0, 8'd1, 64'd0, '1));
        plan.push_back(frame_row(hbm_pkg::FRAME_BYTES, 32'd0, 8'd1, 64'd0,
                                 64'hFFFF_FFFF_FFFF_FFFE));
        // New session restarts the sequence check
        plan.push_back(frame_row(hbm_pkg::FRAME_BYTES, 32'd0, 8'd1, '1, 64'd0));
        plan.push_back(frame_row(hbm_pkg::FRAME_BYTES - 1, 32'd0, 8'd1, 64'h1234, 64'd9));
        plan.push_back(frame_row(hbm_pkg::FRAME_BYTES + 1, 32'd0, 8'd1, 64'h1234, 64'd9));
        // Overlong: the byte position saturates, length check rejects
        plan.push_back(frame_row(70, 32'd0, 8'd1, 64'h1234, 64'd9));
        plan.push_back(frame_row(hbm_pkg::FRAME_BYTES, 32'd1, 8'd1, 64'h7, 64'd0));
        plan.push_back(frame_row(hbm_pkg::FRAME_BYTES, 32'd0, 8'd0, 64'h7, 64'd0));
        // Zero timeout: alive only while no tick has passed
        plan.push_back(write_row(hbm_pkg::CFG_TIMEOUT, 32'd0));
        plan.push_back(write_row(hbm_pkg::CFG_MAGIC, '1));
        plan.push_back(write_row(hbm_pkg::CFG_VERSION, 32'hFF));
        plan.push_back(frame_row(hbm_pkg::FRAME_BYTES, '1, 8'hFF, 64'h5, 64'h5));
        plan.push_back(tick_row(1));
        plan.push_back(frame_row(hbm_pkg::FRAME_BYTES, 32'd0, 8'd1, 64'h6, 64'd0));
        plan.push_back(write_row(hbm_pkg::CFG_TIMEOUT, '1));
        plan.push_back(tick_row(5));
        plan.push_back(write_row(hbm_pkg::CFG_TIMEOUT, 32'd2));
        plan.push_back(tick_row(4));
        plan.push_back(frame_row(hbm_pkg::FRAME_BYTES, '1, 8'hFF, 64'h5, 64'h5));

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_TICKS: begin
                    for (int k = 0; k < plan[i].count; k++) begin
                        send_item(hbm_pkg::OP_TICK, 8'($urandom), 1'($urandom),
                                  plan[i].typed && k == plan[i].count - 1, plan[i].want);
                    end
                end
                ROW_FRAME: begin
                    send_frame(plan[i].count, plan[i].magic, plan[i].version,
                               plan[i].session, plan[i].seq_no, -1, plan[i].typed,
                               plan[i].want);
                end
                default: begin
                    write_reg(plan[i].reg_idx, plan[i].value);
                end
            endcase
        end

        // Random part: each phase sets all registers, then mixes mostly
        // well-formed datagrams with tick bursts, broken datagrams and noise
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    to_val = $urandom_range(1, 30);
                    mg     = $urandom;
                    vr     = 8'($urandom);
                end
                1: begin
                    to_val = 32'd1;
                    mg     = '1;
                    vr     = 8'h00;
                end
                2: begin
                    to_val = '1;
                    mg     = '0;
                    vr     = 8'hFF;
                end
                default: begin
                    to_val = $urandom_range(3, 60);
                    mg     = $urandom;
                    vr     = 8'($urandom);
                end
            endcase
            write_reg(hbm_pkg::CFG_TIMEOUT, to_val);
            write_reg(hbm_pkg::CFG_MAGIC, mg);
            write_reg(hbm_pkg::CFG_VERSION, {24'h0, vr});

            sess_pool[0] = '0;
            sess_pool[1] = '1;
            sess_pool[2] = {$urandom, $urandom};
            sess_pool[3] = {$urandom, $urandom};
            // Run one phase without idling on either side
            calm <= (ph == 2);
            // Back up the block once while the sender keeps offering items
            if (ph == 0) hold_requests <= hold_requests + 1;
            phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;

            while (items_sent < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    // Well-formed: mostly the held session around its sequence
                    if (seen_any && $urandom_range(0, 99) < 60) ss = held_sess;
                    else ss = sess_pool[$urandom_range(0, 3)];
                    if ($urandom_range(0, 99) < 75)
                        sq = held_seq + 64'($urandom_range(0, 5)) - 64'd2;
                    else
                        sq = {$urandom, $urandom};
                    send_frame(hbm_pkg::FRAME_BYTES, cfg_magic, cfg_version, ss, sq, -1,
                               1'b0, '0);
                end else if (roll < 80) begin
                    if ($urandom_range(0, 99) < 85) send_ticks($urandom_range(1, 6));
                    else send_ticks($urandom_range(20, 70));
                end else if (roll < 90) begin
                    // Broken datagram: wrong length or one byte flipped
                    ss = sess_pool[$urandom_range(0, 3)];
                    sq = {$urandom, $urandom};
                    if ($urandom_range(0, 1) == 0)
                        send_frame($urandom_range(1, 40), cfg_magic, cfg_version, ss, sq,
                                   -1, 1'b0, '0);
                    else
                        send_frame(hbm_pkg::FRAME_BYTES, cfg_magic, cfg_version, ss, sq,
                                   $urandom_range(0, hbm_pkg::FRAME_BYTES - 1), 1'b0, '0);
                end else begin
                    // Noise: loose items of any kind
                    repeat ($urandom_range(1, 4)) begin
                        send_item(hbm_pkg::t_op'($urandom_range(0, 1)), 8'($urandom),
                                  1'($urandom), 1'b0, '0);
                    end
                end
            end
        end

        // Drain, let the pipeline settle, then judge the run
        s_axis_tvalid <= 1'b0;
        calm <= 1'b1;
        for (wait_cycles = 0;
             pending_reports.size() != 0 && wait_cycles < DRAIN_LIMIT;
             wait_cycles++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        mismatches += pending_reports.size();
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #12_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: heartbeat_liveness_monitor.f
sv/hbm_pkg.sv
sv/hbm_asm.sv
sv/heartbeat_liveness_monitor.sv
verif/tb.sv
